// ===== rtl/core/mau_pkg.sv =====
`default_nettype none
package mau_pkg;
  localparam int WORD_BITS = 64;
  localparam int LATENCY = 3 * WORD_BITS + 1;

  typedef enum logic [2:0] {
    KIND_REDUCE = 3'd0,
    KIND_NEGATE = 3'd1,
    KIND_ADD    = 3'd2,
    KIND_SUB    = 3'd3,
    KIND_MUL    = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    logic [WORD_BITS-1:0] sa;
    logic [WORD_BITS-1:0] sb;
    logic [WORD_BITS:0]   n;
    logic [WORD_BITS-1:0] r;
  } item_t;
endpackage
`default_nettype wire

// ===== rtl/core/modular_arithmetic_unit.sv =====
`default_nettype none
// Throughput: one word per cycle; the whole chain halts while a result waits.
// Chain: WORD_BITS division cells reduce both operands one bit each, then
// WORD_BITS double/add cells (two stages each) form the product, then one output stage.
// Reset: rst clears all valid bits; no word in flight survives.
module modular_arithmetic_unit
  import mau_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  kind,
  input  wire logic [63:0] operand_a,
  input  wire logic [63:0] operand_b,
  input  wire logic [63:0] modulus,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      remainder_out
);
  logic en;
  logic  rv [WORD_BITS+1];
  item_t ri [WORD_BITS+1];
  logic  mv [WORD_BITS+1];
  item_t mi [WORD_BITS+1];
  logic [WORD_BITS-1:0] nlow;

  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign nlow = modulus[WORD_BITS-1:0];

  always_comb begin
    ri[0].kind = kind;
    ri[0].a = '0;
    ri[0].b = '0;
    ri[0].sa = operand_a[WORD_BITS-1:0];
    ri[0].sb = operand_b[WORD_BITS-1:0];
    ri[0].n = (nlow == '0) ? {1'b1, {WORD_BITS{1'b0}}} : {1'b0, nlow};
    ri[0].r = '0;
    rv[0] = in_valid;
  end

  always_comb begin
    mi[0] = ri[WORD_BITS];
    mi[0].sb = ri[WORD_BITS].b;
    mi[0].r = '0;
    mv[0] = rv[WORD_BITS];
  end

  for (genvar i = 0; i < WORD_BITS; i++) begin : g_red
    mau_red_cell u_red (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(rv[i]), .in_item(ri[i]),
      .out_valid(rv[i+1]), .out_item(ri[i+1])
    );
  end

  for (genvar i = 0; i < WORD_BITS; i++) begin : g_mul
    mau_mul_cell u_mul (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(mv[i]), .in_item(mi[i]),
      .out_valid(mv[i+1]), .out_item(mi[i+1])
    );
  end

  mau_final u_final (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(mv[WORD_BITS]), .in_item(mi[WORD_BITS]),
    .out_valid(out_valid), .result(remainder_out)
  );
endmodule
`default_nettype wire

// ===== rtl/core/mau_red_cell.sv =====
`default_nettype none
module mau_red_cell
  import mau_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire item_t in_item,
  output logic       out_valid,
  output item_t      out_item
);
  item_t item_next;
  logic [WORD_BITS:0] ta, tb;

  always_comb begin
    item_next = in_item;
    ta = {in_item.a, in_item.sa[WORD_BITS-1]};
    tb = {in_item.b, in_item.sb[WORD_BITS-1]};
    if (ta >= in_item.n) ta = ta - in_item.n;
    if (tb >= in_item.n) tb = tb - in_item.n;
    item_next.a = ta[WORD_BITS-1:0];
    item_next.b = tb[WORD_BITS-1:0];
    item_next.sa = {in_item.sa[WORD_BITS-2:0], 1'b0};
    item_next.sb = {in_item.sb[WORD_BITS-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/mau_mul_cell.sv =====
`default_nettype none
module mau_mul_cell
  import mau_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire item_t in_item,
  output logic       out_valid,
  output item_t      out_item
);
  item_t dbl, dbl_next, add_next;
  logic dbl_valid;
  logic [WORD_BITS:0] t, u;

  // doubling half
  always_comb begin
    dbl_next = in_item;
    t = {in_item.r, 1'b0};
    if (t >= in_item.n) t = t - in_item.n;
    dbl_next.r = t[WORD_BITS-1:0];
  end

  // conditional add half
  always_comb begin
    add_next = dbl;
    u = {1'b0, dbl.r} + {1'b0, dbl.a};
    if (u >= dbl.n) u = u - dbl.n;
    if (dbl.sb[WORD_BITS-1]) add_next.r = u[WORD_BITS-1:0];
    add_next.sb = {dbl.sb[WORD_BITS-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dbl_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      dbl_valid <= in_valid;
      out_valid <= dbl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dbl <= dbl_next;
      out_item <= add_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/mau_final.sv =====
`default_nettype none
module mau_final
  import mau_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire item_t       in_item,
  output logic             out_valid,
  output logic [63:0]      result
);
  logic [WORD_BITS:0] s;
  logic [WORD_BITS-1:0] res_next;

  always_comb begin
    s = '0;
    res_next = '0;
    case (in_item.kind)
      KIND_REDUCE: res_next = in_item.a;
      KIND_NEGATE: begin
        s = in_item.n - {1'b0, in_item.a};
        res_next = (in_item.a == '0) ? '0 : s[WORD_BITS-1:0];
      end
      KIND_ADD: begin
        s = {1'b0, in_item.a} + {1'b0, in_item.b};
        if (s >= in_item.n) s = s - in_item.n;
        res_next = s[WORD_BITS-1:0];
      end
      KIND_SUB: begin
        if (in_item.a >= in_item.b) begin
          s = {1'b0, in_item.a} - {1'b0, in_item.b};
        end else begin
          s = in_item.n - ({1'b0, in_item.b} - {1'b0, in_item.a});
        end
        res_next = s[WORD_BITS-1:0];
      end
      KIND_MUL: res_next = in_item.r;
      default: res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= 64'(res_next);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/mau_checker.sv =====
`default_nettype none
module mau_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] remainder_out
);
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(remainder_out))
    else $error("result dropped or changed while stalled");
  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .remainder_out(remainder_out)
);
`default_nettype wire

// ===== test/modular_arithmetic_unit_tb.sv =====
module modular_arithmetic_unit_tb;
  import mau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int N_RANDOM = 1650;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  kind = '0;
  logic [63:0] operand_a = '0;
  logic [63:0] operand_b = '0;
  logic [63:0] modulus = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] remainder_out;

  logic [63:0] pending_rem[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle_pct = 12;
  int          recv_idle_pct = 51;
  logic        stim_done = 1'b0;

  typedef struct {
    logic [2:0]  k;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] n;
    logic        known;
    logic [63:0] r;
  } row_t;

  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [2:0] KIND_UNUSED5 = 3'd5;
  localparam logic [2:0] KIND_UNUSED6 = 3'd6;
  localparam logic [2:0] KIND_UNUSED7 = 3'd7;

  row_t directed[] = '{
    '{KIND_REDUCE, ONES, 64'd0, 64'd0, 1'b1, ONES},
    '{KIND_REDUCE, ONES, 64'd0, 64'd10, 1'b1, 64'd5},
    '{KIND_REDUCE, 64'd7, 64'd0, 64'd1, 1'b1, 64'd0},
    '{KIND_NEGATE, 64'd0, 64'd0, 64'd13, 1'b1, 64'd0},
    '{KIND_NEGATE, 64'd26, 64'd0, 64'd13, 1'b1, 64'd0},
    '{KIND_NEGATE, 64'd1, 64'd0, 64'd0, 1'b1, ONES},
    '{KIND_NEGATE, ONES, 64'd0, ONES, 1'b1, 64'd0},
    '{KIND_ADD, ONES, ONES, 64'd0, 1'b1, ONES - 64'd1},
    '{KIND_ADD, ONES - 64'd1, ONES - 64'd1, ONES, 0, 0},
    '{KIND_ADD, 64'd5, 64'd9, 64'd7, 1'b1, 64'd0},
    '{KIND_SUB, 64'd0, 64'd1, 64'd0, 1'b1, ONES},
    '{KIND_SUB, 64'd3, 64'd5, 64'd7, 1'b1, 64'd5},
    '{KIND_SUB, ONES, 64'd0, ONES, 1'b1, 64'd0},
    '{KIND_MUL, ONES, ONES, 64'd0, 1'b1, 64'd1},
    '{KIND_MUL, ONES - 64'd1, ONES - 64'd1, ONES, 0, 0},
    '{KIND_MUL, ONES, ONES, 64'h8000_0000_0000_0001, 0, 0},
    '{KIND_MUL, 64'd123456789, 64'd987654321, 64'd1000000007, 0, 0},
    '{KIND_MUL, ONES, 64'd0, 64'd17, 1'b1, 64'd0},
    '{KIND_UNUSED5, ONES, ONES, 64'd11, 1'b1, 64'd0},
    '{KIND_UNUSED6, 64'd3, 64'd4, 64'd0, 1'b1, 64'd0},
    '{KIND_UNUSED7, ONES, ONES, ONES, 1'b1, 64'd0}
  };

  modular_arithmetic_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .operand_a(operand_a), .operand_b(operand_b), .modulus(modulus),
    .out_valid(out_valid), .out_ready(out_ready), .remainder_out(remainder_out)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] mod_result(logic [2:0] k, logic [63:0] a,
                                             logic [63:0] b, logic [63:0] n);
    logic [64:0]  m;
    logic [64:0]  ra;
    logic [64:0]  rb;
    logic [129:0] t;
    m = (n == 0) ? {1'b1, 64'd0} : {1'b0, n};
    ra = {1'b0, a} % m;
    rb = {1'b0, b} % m;
    case (k)
      KIND_REDUCE: t = ra;
      KIND_NEGATE: t = (ra == 0) ? 0 : m - ra;
      KIND_ADD:    t = (ra + rb) % m;
      KIND_SUB:    t = (ra + m - rb) % m;
      KIND_MUL:    t = (ra * rb) % m;
      default:     t = 0;
    endcase
    return t[63:0];
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  task automatic send_word(logic [2:0] k, logic [63:0] a, logic [63:0] b,
                           logic [63:0] n);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    operand_a <= a;
    operand_b <= b;
    modulus <= n;
    pending_rem.push_back(mod_result(k, a, b, n));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_val(int sel);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case (sel)
      0: return v;
      1: return v >> $urandom_range(63);
      2: return ONES - $urandom_range(3);
      3: return $urandom_range(16);
      4: return 64'd1 << $urandom_range(63);
      default: return v;
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_rem.size() == 0) begin
          report_mismatch("unexpected word", remainder_out, 64'd0);
        end else begin
          if (remainder_out !== pending_rem[0])
            report_mismatch("remainder_out", remainder_out, pending_rem[0]);
          void'(pending_rem.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    logic [63:0] want;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      if (directed[i].known) begin
        want = mod_result(directed[i].k, directed[i].a, directed[i].b, directed[i].n);
        if (want !== directed[i].r)
          report_mismatch("table entry", want, directed[i].r);
      end
      send_word(directed[i].k, directed[i].a, directed[i].b, directed[i].n);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 12;
      end
      if (i == N_RANDOM / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_rem.size() != 0);
      end
      if (i == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_word($urandom_range(7), rand_val($urandom_range(5)),
                rand_val($urandom_range(5)), rand_val($urandom_range(5)));
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_rem.size() != 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && pending_rem.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
